// File: hdl/kmer_level_lookup_core_defines.svh
// ----------------------------------------------------------------------------
// kmer level lookup assertion macros
// shared concurrent assertion forms for the lookup core
// ----------------------------------------------------------------------------
`ifndef KMER_LEVEL_LOOKUP_CORE_DEFINES_SVH
`define KMER_LEVEL_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KLL_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define KLL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/kll_pkg.sv
// ----------------------------------------------------------------------------
// kll_pkg
// types and constants shared by the kmer level lookup controller and datapath
// ----------------------------------------------------------------------------
package kll_pkg;

  // fixed field widths of the ports
  localparam int FIELD_W  = 24;
  localparam int INDEX_W  = 18;
  localparam int BASE_W   = 4;
  localparam int KCFG_W   = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USE_K          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_K        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_STDDEV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STDDEV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_LEVEL    = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_K    = 2'd2;

  // input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_BASE  = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic read_en;   // issue one table read
    logic load_out;  // load the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_lookup;  // accepted base yields a level result
    logic need_error;   // accepted base yields an error result
    logic last_read;    // current read is the final one of the walk
    logic out_free;     // output register can take a result
  } dp_status_t;

endpackage

// File: hdl/kll_ctrl.sv
// ----------------------------------------------------------------------------
// kll_ctrl
// sequencer for input transfers, table walk and result hand-off
// ----------------------------------------------------------------------------
module kll_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  kll_pkg::dp_status_t st,
  output kll_pkg::ctrl_cmd_t  cmd
);
  import kll_pkg::*;

  state_t state;
  state_t state_next;

  // command decode
  always_comb begin
    cmd.accept   = in_valid && (state == S_IDLE);
    cmd.read_en  = (state == S_READ);
    cmd.load_out = (state == S_OUT) && st.out_free;
  end

  assign in_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          if (st.need_error) begin
            state_next = S_OUT;
          end else if (st.need_lookup) begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        if (st.last_read) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/kll_datapath.sv
// ----------------------------------------------------------------------------
// kll_datapath
// config registers, base window, level tables, accumulators and output register
// ----------------------------------------------------------------------------
module kll_datapath #(
  parameter int MAX_K      = 9,
  parameter int LEVEL_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_write_en,
  input  logic [kll_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [kll_pkg::FIELD_W-1:0]           cfg_data,
  // input payload
  input  logic                                  cmd_in,
  input  logic [kll_pkg::INDEX_W-1:0]           entry_index,
  input  logic signed [kll_pkg::FIELD_W-1:0]    entry_mean,
  input  logic [kll_pkg::FIELD_W-1:0]           entry_stddev,
  input  logic [kll_pkg::BASE_W-1:0]            base_code,
  input  logic                                  seq_start,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [kll_pkg::FIELD_W-1:0]    kmer_mean,
  output logic [kll_pkg::FIELD_W-1:0]           kmer_sd,
  output logic [kll_pkg::FIELD_W-1:0]           dwell,
  output logic [kll_pkg::INDEX_W-1:0]           kmer_code,
  output logic [kll_pkg::STATUS_W-1:0]          status,
  // controller link
  input  kll_pkg::ctrl_cmd_t                    cmd,
  output kll_pkg::dp_status_t                   st
);
  import kll_pkg::*;

  localparam int TB    = 2 * MAX_K;
  localparam int DEPTH = 1 << TB;
  localparam int SW    = LEVEL_BITS + TB;
  localparam int SHW   = $clog2(TB + 1);
  localparam logic [KCFG_W-1:0] MAX_K_V = KCFG_W'(MAX_K);

  // configuration registers
  logic [KCFG_W-1:0]  use_k;
  logic [KCFG_W-1:0]  model_k;
  logic               has_stddev;
  logic [FIELD_W-1:0] sd_fallback;
  logic [FIELD_W-1:0] dwell_level;

  // sequence state
  logic [TB-1:0]     window;
  logic [KCFG_W-1:0] bases_seen;
  logic              aborted;

  // table walk and accumulation
  logic [LEVEL_BITS-1:0] mean_mem [DEPTH];
  logic [LEVEL_BITS-1:0] sd_mem   [DEPTH];
  logic [TB-1:0]         rd_addr;
  logic [TB-1:0]         rd_cnt;
  logic [LEVEL_BITS-1:0] rd_mean;
  logic [LEVEL_BITS-1:0] rd_sd;
  logic                  rd_vld;
  logic signed [SW-1:0]  mean_acc;
  logic [SW-1:0]         sd_acc;
  logic [STATUS_W-1:0]   res_code;

  // decode of the presented item
  logic              is_base;
  logic              aborted_eff;
  logic              k_bad;
  logic              base_bad;
  logic [TB-1:0]     window_clr;
  logic [KCFG_W-1:0] bases_clr;
  logic [TB-1:0]     win_mask;
  logic [TB-1:0]     window_next;
  logic [KCFG_W-1:0] bases_next;
  logic [KCFG_W-1:0] k_diff;
  logic [SHW-1:0]    shift;
  logic [TB-1:0]     count_m1;
  logic [TB-1:0]     start_addr;

  // result formatting
  logic signed [SW-1:0]  mean_shift;
  logic [SW-1:0]         sd_shift;
  logic [LEVEL_BITS-1:0] mean_lvl;
  logic [LEVEL_BITS-1:0] sd_lvl;

  // k configuration check and decimation shift
  always_comb begin
    k_bad    = (use_k == '0) || (use_k > MAX_K_V) || (model_k > MAX_K_V) || (use_k > model_k);
    k_diff   = model_k - use_k;
    shift    = SHW'({k_diff, 1'b0});
    count_m1 = ~({TB{1'b1}} << shift);
  end

  // window update for an accepted base
  always_comb begin
    is_base     = (cmd_in == CMD_BASE);
    aborted_eff = aborted && !seq_start;
    window_clr  = seq_start ? '0 : window;
    bases_clr   = seq_start ? '0 : bases_seen;
    base_bad    = (base_code > BASE_W'(3));
    win_mask    = ~({TB{1'b1}} << {use_k, 1'b0});
    window_next = ((window_clr << 2) | TB'(base_code[1:0])) & win_mask;
    bases_next  = (bases_clr == {KCFG_W{1'b1}}) ? bases_clr : bases_clr + KCFG_W'(1);
    start_addr  = window_next << shift;
  end

  // status toward the controller
  always_comb begin
    st.need_error  = is_base && !aborted_eff && (k_bad || base_bad);
    st.need_lookup = is_base && !aborted_eff && !k_bad && !base_bad && (bases_next >= use_k);
    st.last_read   = (rd_cnt == '0);
    st.out_free    = !out_valid || !out_stall;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      use_k       <= KCFG_W'(6);
      model_k     <= KCFG_W'(6);
      has_stddev  <= 1'b1;
      sd_fallback <= '0;
      dwell_level <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_USE_K:          use_k       <= cfg_data[KCFG_W-1:0];
        CFG_MODEL_K:        model_k     <= cfg_data[KCFG_W-1:0];
        CFG_HAS_STDDEV:     has_stddev  <= cfg_data[0];
        CFG_DEFAULT_STDDEV: sd_fallback <= cfg_data;
        CFG_DWELL_LEVEL:    dwell_level <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequence state on a base transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      bases_seen <= '0;
      aborted    <= 1'b0;
    end else if (cmd.accept && is_base) begin
      if (aborted_eff) begin
        window     <= window_clr;
        bases_seen <= bases_clr;
        aborted    <= 1'b1;
      end else if (k_bad || base_bad) begin
        window     <= window_clr;
        bases_seen <= bases_clr;
        aborted    <= 1'b1;
      end else begin
        window     <= window_next;
        bases_seen <= bases_next;
        aborted    <= 1'b0;
      end
    end
  end

  // level tables: write on table transfer, registered read during the walk
  always_ff @(posedge clk) begin
    if (cmd.accept && (cmd_in == CMD_WRITE)) begin
      mean_mem[TB'(entry_index)] <= LEVEL_BITS'($unsigned(entry_mean));
      sd_mem[TB'(entry_index)]   <= LEVEL_BITS'(entry_stddev);
    end
    if (cmd.read_en) begin
      rd_mean <= mean_mem[rd_addr];
      rd_sd   <= sd_mem[rd_addr];
    end
  end

  // read data valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.read_en;
    end
  end

  // walk address, count, accumulators and result code
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_addr  <= start_addr;
      rd_cnt   <= count_m1;
      mean_acc <= '0;
      sd_acc   <= '0;
      res_code <= k_bad ? ST_BAD_K : (base_bad ? ST_BAD_BASE : ST_OK);
    end else begin
      if (cmd.read_en) begin
        rd_addr <= rd_addr + TB'(1);
        rd_cnt  <= rd_cnt - TB'(1);
      end
      if (rd_vld) begin
        mean_acc <= mean_acc + SW'($signed(rd_mean));
        sd_acc   <= sd_acc + SW'(rd_sd);
      end
    end
  end

  // average by shift, floor for the signed mean
  always_comb begin
    mean_shift = mean_acc >>> shift;
    sd_shift   = sd_acc >> shift;
    mean_lvl   = mean_shift[LEVEL_BITS-1:0];
    sd_lvl     = sd_shift[LEVEL_BITS-1:0];
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= res_code;
      if (res_code == ST_OK) begin
        kmer_mean <= FIELD_W'(mean_lvl);
        kmer_sd   <= has_stddev ? FIELD_W'(sd_lvl) : sd_fallback;
        dwell     <= dwell_level;
        kmer_code <= INDEX_W'(window);
      end else begin
        kmer_mean <= '0;
        kmer_sd   <= '0;
        dwell     <= '0;
        kmer_code <= '0;
      end
    end
  end

endmodule

// File: hdl/kmer_level_lookup_core.sv
// ----------------------------------------------------------------------------
// kmer_level_lookup_core
// pore-model level lookup: base stream in, mean/stddev/dwell per k-mer out
// ----------------------------------------------------------------------------
// One item is in flight at a time. A table write (cmd 0) and a base that
// yields no result leave the block idle; a base that yields an error result
// goes to the output state. A base that yields a level walks the
// 4^(model_k-use_k) entries that share its prefix: the mean and stddev
// tables have one read port each, the walk reads one entry per cycle, a
// drain state lets the last read land and the output state loads the output
// register. A result waiting in the output register does not block the next
// input transfer; it only holds the block before it loads another result.
// The tables are not cleared at reset; entries must be written before use.
module kmer_level_lookup_core #(
  parameter int MAX_K      = 9,
  parameter int LEVEL_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write_en,
  input  logic [kll_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kll_pkg::FIELD_W-1:0]        cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [kll_pkg::INDEX_W-1:0]        entry_index,
  input  logic signed [kll_pkg::FIELD_W-1:0] entry_mean,
  input  logic [kll_pkg::FIELD_W-1:0]        entry_stddev,
  input  logic [kll_pkg::BASE_W-1:0]         base_code,
  input  logic                               seq_start,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [kll_pkg::FIELD_W-1:0] kmer_mean,
  output logic [kll_pkg::FIELD_W-1:0]        kmer_sd,
  output logic [kll_pkg::FIELD_W-1:0]        dwell,
  output logic [kll_pkg::INDEX_W-1:0]        kmer_code,
  output logic [kll_pkg::STATUS_W-1:0]       status
);
  import kll_pkg::*;

  `include "kmer_level_lookup_core_defines.svh"

  ctrl_cmd_t  ctl;
  dp_status_t dps;
  logic       res_due;

  // sequencer
  kll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (dps),
    .cmd      (ctl)
  );

  // datapath
  kll_datapath #(
    .MAX_K      (MAX_K),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_in       (cmd),
    .entry_index  (entry_index),
    .entry_mean   (entry_mean),
    .entry_stddev (entry_stddev),
    .base_code    (base_code),
    .seq_start    (seq_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kmer_mean    (kmer_mean),
    .kmer_sd      (kmer_sd),
    .dwell        (dwell),
    .kmer_code    (kmer_code),
    .status       (status),
    .cmd          (ctl),
    .st           (dps)
  );

  // transfer that owes a result
  assign res_due = ctl.accept && (dps.need_lookup || dps.need_error);

  // checks on the control/datapath hand-off
  `KLL_ASSERT(a_load_when_free, clk, rst, ctl.load_out, !out_valid || !out_stall, "load on full")
  `KLL_ASSERT(a_read_when_busy, clk, rst, ctl.read_en, in_stall && !ctl.accept, "read overlap")
  `KLL_ASSERT_NEXT(a_busy_after_result, clk, rst, res_due, in_stall, "result item not held")

endmodule

// File: tb/level_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_checker
// watches the register port and both channels of the lookup core, keeps its
// own copy of the tables, window and settings, predicts the level or error
// result of each base transfer and compares it with the returned result
// ----------------------------------------------------------------------------
module level_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [kll_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kll_pkg::FIELD_W-1:0]         cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                cmd,
  input  logic [kll_pkg::INDEX_W-1:0]         entry_index,
  input  logic signed [kll_pkg::FIELD_W-1:0]  entry_mean,
  input  logic [kll_pkg::FIELD_W-1:0]         entry_stddev,
  input  logic [kll_pkg::BASE_W-1:0]          base_code,
  input  logic                                seq_start,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [kll_pkg::FIELD_W-1:0]  kmer_mean,
  input  logic [kll_pkg::FIELD_W-1:0]         kmer_sd,
  input  logic [kll_pkg::FIELD_W-1:0]         dwell,
  input  logic [kll_pkg::INDEX_W-1:0]         kmer_code,
  input  logic [kll_pkg::STATUS_W-1:0]        status,
  output int                                  fail_count,
  output int                                  pending_count
);
  import kll_pkg::*;

  localparam int KMAX       = 9;
  localparam int RESET_K    = 6;
  localparam int SEEN_LIMIT = 15;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [FIELD_W-1:0] mean;
    logic [FIELD_W-1:0]        sd;
    logic [FIELD_W-1:0]        dw;
    logic [INDEX_W-1:0]        kmer;
    logic [STATUS_W-1:0]       status;
  } level_t;

  // table copy, filled by write transfers
  logic signed [FIELD_W-1:0] mean_tab [int unsigned];
  logic [FIELD_W-1:0]        sd_tab   [int unsigned];

  // levels still owed by the core, oldest first
  level_t expected_levels [$];

  // settings copy
  logic [KCFG_W-1:0]  k_use;
  logic [KCFG_W-1:0]  k_model;
  logic               sd_from_table;
  logic [FIELD_W-1:0] sd_default;
  logic [FIELD_W-1:0] dwell_value;

  // sliding window of the current sequence
  logic [INDEX_W-1:0] win;
  logic [3:0]         seen;
  logic               aborted;

  int fails = 0;

  // one base: slide the window and queue the level or error it yields
  task automatic take_base(input logic [BASE_W-1:0] b, input logic st);
    level_t             r;
    logic [INDEX_W-1:0] mask;
    int unsigned        shift;
    int unsigned        first;
    int unsigned        i;
    longint signed      mean_sum;
    longint unsigned    sd_sum;
    r = '0;
    if (st) begin
      win = '0;
      seen = '0;
      aborted = 1'b0;
    end
    if (!aborted) begin
      if (k_use == 0 || k_use > KMAX || k_model > KMAX || k_use > k_model) begin
        r.status = ST_BAD_K;
        aborted = 1'b1;
        expected_levels.push_back(r);
      end else if (b > 3) begin
        r.status = ST_BAD_BASE;
        aborted = 1'b1;
        expected_levels.push_back(r);
      end else begin
        mask = INDEX_W'((32'd1 << (2 * k_use)) - 1);
        win = INDEX_W'({win, 2'b00} | INDEX_W'(b)) & mask;
        if (seen < SEEN_LIMIT) seen++;
        if (seen >= k_use) begin
          // average over the block of entries that share this prefix
          shift = 2 * (k_model - k_use);
          first = 32'(win) << shift;
          mean_sum = 0;
          sd_sum = 0;
          for (i = 0; i < (32'd1 << shift); i++) begin
            mean_sum += longint'(mean_tab[first + i]);
            sd_sum += 64'(sd_tab[first + i]);
          end
          r.mean = FIELD_W'(mean_sum >>> shift);
          r.sd = sd_from_table ? FIELD_W'(sd_sum >> shift) : sd_default;
          r.dw = dwell_value;
          r.kmer = win;
          r.status = ST_OK;
          expected_levels.push_back(r);
        end
      end
    end
  endtask

  // compare one result transfer with the oldest expectation
  task automatic check_level();
    level_t got;
    level_t want;
    got.mean = kmer_mean;
    got.sd = kmer_sd;
    got.dw = dwell;
    got.kmer = kmer_code;
    got.status = status;
    if (expected_levels.size() == 0) begin
      fails++;
      if (fails <= REPORT_MAX)
        $display("%0t: result with none expected: mean %h stddev %h dwell %h kmer %h status %0d",
                 $time, got.mean, got.sd, got.dw, got.kmer, got.status);
    end else begin
      want = expected_levels.pop_front();
      if (got.mean !== want.mean || got.sd !== want.sd || got.dw !== want.dw ||
          got.kmer !== want.kmer || got.status !== want.status) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("%0t: mismatch exp/act mean %h/%h sd %h/%h dw %h/%h kmer %h/%h st %0d/%0d",
                   $time, want.mean, got.mean, want.sd, got.sd, want.dw, got.dw,
                   want.kmer, got.kmer, want.status, got.status);
      end
    end
  endtask

  // follow the register port and both channels
  always @(posedge clk) begin
    if (rst) begin
      k_use = KCFG_W'(RESET_K);
      k_model = KCFG_W'(RESET_K);
      sd_from_table = 1'b1;
      sd_default = '0;
      dwell_value = '0;
      win = '0;
      seen = '0;
      aborted = 1'b0;
      expected_levels.delete();
    end else begin
      if (out_valid && !out_stall) check_level();
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_USE_K:          k_use = cfg_data[KCFG_W-1:0];
          CFG_MODEL_K:        k_model = cfg_data[KCFG_W-1:0];
          CFG_HAS_STDDEV:     sd_from_table = cfg_data[0];
          CFG_DEFAULT_STDDEV: sd_default = cfg_data;
          CFG_DWELL_LEVEL:    dwell_value = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (cmd == CMD_WRITE) begin
          mean_tab[entry_index] = entry_mean;
          sd_tab[entry_index] = entry_stddev;
        end else begin
          take_base(base_code, seq_start);
        end
      end
    end
    fail_count <= fails;
    pending_count <= expected_levels.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives table writes and base sequences into the lookup core under a series
// of k settings, with bursty input and a patterned output stall; the level
// checker beside the core predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
  import kll_pkg::*;

  localparam int KMAX        = 9;
  localparam int RESET_K     = 6;
  localparam int SEEN_LIMIT  = 15;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HOLD} stall_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_USE_K;
  logic [FIELD_W-1:0]        cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      cmd = CMD_WRITE;
  logic [INDEX_W-1:0]        entry_index = '0;
  logic signed [FIELD_W-1:0] entry_mean = '0;
  logic [FIELD_W-1:0]        entry_stddev = '0;
  logic [BASE_W-1:0]         base_code = '0;
  logic                      seq_start = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [FIELD_W-1:0] kmer_mean;
  logic [FIELD_W-1:0]        kmer_sd;
  logic [FIELD_W-1:0]        dwell;
  logic [INDEX_W-1:0]        kmer_code;
  logic [STATUS_W-1:0]       status;

  int fail_count;
  int pending_count;
  int cycles = 0;
  int xfers = 0;
  int burst_left = 0;
  int stall_hold = 0;
  stall_mode_t stall_mode = STALL_NONE;

  // stimulus-side view of the window, used to write table entries before
  // any base reads them
  logic [KCFG_W-1:0]  cur_use_k = KCFG_W'(RESET_K);
  logic [KCFG_W-1:0]  cur_model_k = KCFG_W'(RESET_K);
  logic [INDEX_W-1:0] trk_window = '0;
  logic [3:0]         trk_seen = '0;
  logic               trk_aborted = 1'b0;
  bit                 written [int unsigned];

  always #10 clk = ~clk;

  kmer_level_lookup_core DUT (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .entry_index(entry_index),
    .entry_mean(entry_mean), .entry_stddev(entry_stddev), .base_code(base_code),
    .seq_start(seq_start),
    .out_valid(out_valid), .out_stall(out_stall), .kmer_mean(kmer_mean),
    .kmer_sd(kmer_sd), .dwell(dwell), .kmer_code(kmer_code), .status(status)
  );

  level_checker levels (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .entry_index(entry_index),
    .entry_mean(entry_mean), .entry_stddev(entry_stddev), .base_code(base_code),
    .seq_start(seq_start),
    .out_valid(out_valid), .out_stall(out_stall), .kmer_mean(kmer_mean),
    .kmer_sd(kmer_sd), .dwell(dwell), .kmer_code(kmer_code), .status(status),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // run limit, far above the slowest correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall, in a pattern chosen at random from four
  always @(posedge clk) begin
    if (cycles % 128 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: out_stall <= (cycles % 6) < 2;
      default: begin
        if (stall_hold == 0) begin
          stall_hold = $urandom_range(1, 20);
          out_stall <= ~out_stall;
        end else begin
          stall_hold--;
        end
      end
    endcase
  end

  // level values with the extremes weighted in
  function automatic logic [FIELD_W-1:0] pick_level();
    case ($urandom_range(0, 15))
      0:       return 24'h000000;
      1:       return 24'h7FFFFF;
      2:       return 24'h800000;
      3:       return 24'hFFFFFF;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // one input transfer, in bursts with random gaps
  task automatic send_item(input logic c, input logic [INDEX_W-1:0] idx,
                           input logic [FIELD_W-1:0] m, input logic [FIELD_W-1:0] s,
                           input logic [BASE_W-1:0] b, input logic st);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    entry_index <= idx;
    entry_mean <= m;
    entry_stddev <= s;
    base_code <= b;
    seq_start <= st;
    do @(posedge clk); while (in_stall);
    xfers++;
  endtask

  task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic [FIELD_W-1:0] m,
                             input logic [FIELD_W-1:0] s);
    send_item(CMD_WRITE, idx, m, s, BASE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    written[idx] = 1'b1;
  endtask

  // one base; entries the resulting window will average are written first
  task automatic send_base(input logic [BASE_W-1:0] b, input logic st);
    logic [INDEX_W-1:0] nwin;
    logic [INDEX_W-1:0] mask;
    logic [3:0]         nseen;
    logic               nab;
    logic               hit;
    int unsigned        shift;
    int unsigned        first;
    int unsigned        i;
    nwin = st ? '0 : trk_window;
    nseen = st ? '0 : trk_seen;
    nab = st ? 1'b0 : trk_aborted;
    hit = 1'b0;
    if (!nab) begin
      if (cur_use_k == 0 || cur_use_k > KMAX || cur_model_k > KMAX ||
          cur_use_k > cur_model_k || b > 3) begin
        nab = 1'b1;
      end else begin
        mask = INDEX_W'((32'd1 << (2 * cur_use_k)) - 1);
        nwin = INDEX_W'({nwin, 2'b00} | INDEX_W'(b)) & mask;
        if (nseen < SEEN_LIMIT) nseen++;
        hit = nseen >= cur_use_k;
      end
    end
    if (hit) begin
      shift = 2 * (cur_model_k - cur_use_k);
      first = 32'(nwin) << shift;
      for (i = 0; i < (32'd1 << shift); i++)
        if (!written.exists(first + i))
          write_entry(INDEX_W'(first + i), pick_level(), pick_level());
    end
    send_item(CMD_BASE, INDEX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom), b, st);
    trk_window = nwin;
    trk_seen = nseen;
    trk_aborted = nab;
  endtask

  // a run of bases, now and then an invalid one
  task automatic send_run(input int len, input int alpha, input logic st);
    int j;
    logic [BASE_W-1:0] b;
    for (j = 0; j < len; j++) begin
      b = ($urandom_range(0, 99) < 4) ? BASE_W'($urandom_range(4, 15))
                                      : BASE_W'($urandom_range(0, alpha));
      send_base(b, st && j == 0);
    end
  endtask

  // stop driving and let every owed result drain
  task automatic idle_wait(input int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_config(input logic [KCFG_W-1:0] uk, input logic [KCFG_W-1:0] mk,
                            input logic hs, input logic [FIELD_W-1:0] dsd,
                            input logic [FIELD_W-1:0] dw);
    idle_wait(8);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_USE_K;
    cfg_data <= FIELD_W'(uk);
    @(posedge clk);
    cfg_index <= CFG_MODEL_K;
    cfg_data <= FIELD_W'(mk);
    @(posedge clk);
    cfg_index <= CFG_HAS_STDDEV;
    cfg_data <= FIELD_W'(hs);
    @(posedge clk);
    cfg_index <= CFG_DEFAULT_STDDEV;
    cfg_data <= dsd;
    @(posedge clk);
    cfg_index <= CFG_DWELL_LEVEL;
    cfg_data <= dw;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_use_k = uk;
    cur_model_k = mk;
  endtask

  // mostly fresh sequences, some continued runs and stray table writes
  task automatic run_phase(input int budget, input int alpha);
    int start;
    int r;
    start = xfers;
    while (xfers - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        write_entry(INDEX_W'($urandom), pick_level(), pick_level());
      else if (r < 14)
        send_run($urandom_range(1, 3), alpha, 1'b0);
      else
        send_run($urandom_range(1, 20), alpha, 1'b1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes under the reset settings
    write_entry(18'h00000, 24'h7FFFFF, 24'hFFFFFF);
    write_entry(18'h3FFFF, 24'h800000, 24'h000000);
    write_entry(18'h00FFF, 24'h800000, 24'hFFFFFF);
    send_base(4'd0, 1'b1);
    repeat (5) send_base(4'd0, 1'b0);
    repeat (6) send_base(4'd3, 1'b0);
    // invalid base aborts, later bases ignored until a new start
    send_base(4'd15, 1'b0);
    send_base(4'd2, 1'b0);
    // short sequences cut off by a new start before the window fills
    send_base(4'd1, 1'b1);
    send_base(4'd2, 1'b0);
    send_base(4'd1, 1'b1);

    // widest window, top table entry
    set_config(4'd9, 4'd9, 1'b1, 24'h000000, 24'h000000);
    send_base(4'd3, 1'b1);
    repeat (8) send_base(4'd3, 1'b0);
    run_phase(90, 3);

    set_config(4'd1, 4'd1, 1'b0, 24'hFFFFFF, 24'hFFFFFF);
    run_phase(50, 3);

    set_config(4'd3, 4'd3, 1'b1, FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(50, 3);

    // averaged lookups
    set_config(4'd5, 4'd6, 1'b1, FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(60, 3);

    set_config(4'd7, 4'd9, 1'b0, FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(60, 1);

    set_config(4'd1, 4'd4, 1'b1, FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(40, 3);

    // bad k settings
    set_config(4'd0, 4'd6, 1'b1, FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(15, 3);
    set_config(4'd10, 4'd9, 1'b0, FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(15, 3);
    set_config(4'd4, 4'd12, 1'b1, FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(15, 3);
    set_config(4'd7, 4'd5, 1'b0, FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(15, 3);
    set_config(4'd15, 4'd15, 1'b1, FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(15, 3);

    set_config(4'd8, 4'd9, 1'b1, FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(60, 3);

    idle_wait(20);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/kll_pkg.sv
hdl/kll_ctrl.sv
hdl/kll_datapath.sv
hdl/kmer_level_lookup_core.sv
tb/level_checker.sv
tb/testbench.sv
